/* hdl/lbp_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lbp_pkg
// Shared constants, codes and types for the 3x3 local binary pattern filter.
// ----------------------------------------------------------------------------
package lbp_pkg;

    // Largest image row that the line buffer holds
    localparam int MAX_WIDTH   = 1024;
    localparam int COL_W       = $clog2(MAX_WIDTH);
    localparam int WEFF_W      = COL_W + 1;

    // Field and register widths
    localparam int WIDTH_REG_W  = 11;
    localparam int HEIGHT_W     = 16;
    localparam int PIX_W        = 8;
    localparam int CODE_W       = 8;
    localparam int CFG_INDEX_W  = 1;
    localparam int CFG_DATA_W   = 16;

    // Reset values of the configuration registers
    localparam int WIDTH_RESET  = 640;
    localparam int HEIGHT_RESET = 480;

    // Window geometry: WIN_DIM x WIN_DIM pixels, row-major, oldest column first
    localparam int WIN_DIM  = 3;
    localparam int WIN_SIZE = WIN_DIM * WIN_DIM;
    localparam int WIN_CTR  = WIN_SIZE / 2;

    // Result queue
    localparam int OUT_DEPTH = 3;
    localparam int OUT_PTR_W = $clog2(OUT_DEPTH);
    localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 1);

    typedef logic [WEFF_W-1:0]   weff_t;
    typedef logic [COL_W-1:0]    col_t;
    typedef logic [HEIGHT_W-1:0] row_t;
    typedef logic [PIX_W-1:0]    pix_t;

    typedef enum logic {
        OP_PIXEL = 1'b0,
        OP_DRAIN = 1'b1
    } op_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_IMAGE_WIDTH  = 1'b0,
        REG_IMAGE_HEIGHT = 1'b1
    } cfg_reg_t;

    // Which neighbours of the centre lie inside the image
    typedef struct packed {
        logic top;
        logic bottom;
        logic left;
        logic right;
    } nbr_mask_t;

    // One result transaction
    typedef struct packed {
        logic [CODE_W-1:0] code;
        logic              last;
    } result_t;

endpackage : lbp_pkg
`default_nettype wire

/* hdl/lbp_filter_3x3.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lbp_filter_3x3
// Streaming 3x3 local binary pattern filter over 8-bit grey pixels in raster
// order, with two line buffers, a 3x3 window and a small result queue.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake               Payload
//  -------   ---------------------   --------------------------------------
//  pixel     pixel_valid/pixel_stall operation (0 pixel, 1 drain), pixel_value
//  code      code_valid/code_stall   lbp_code, last_code
//  cfg       cfg_valid/cfg_ready     cfg_index (0 width, 1 height), cfg_data
//
//  One transaction per clock is accepted on the pixel channel while pixel_stall
//  is low. A result is registered in the second stage before it enters the
//  queue; the code of a pixel is caused by the transaction image_width+1 items
//  later, so image_width+1 drains flush the tail of the image. The rate is set
//  by the line buffer RAM, read once per item with forwarding of the write of
//  the previous item. Reset clears positions and queue; line buffer and window
//  need no clearing, as the neighbour mask keeps stale entries out of a code.
//  pixel_stall rises when the three-entry result queue could fill, and during
//  a configuration write. code_stall only holds the queue head.
//
module lbp_filter_3x3 (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    // pixel channel
    input  wire logic                               pixel_valid,
    output logic                                    pixel_stall,
    input  wire logic                               operation,
    input  wire logic [lbp_pkg::PIX_W-1:0]          pixel_value,
    // code channel
    output logic                                    code_valid,
    input  wire logic                               code_stall,
    output logic      [lbp_pkg::CODE_W-1:0]         lbp_code,
    output logic                                    last_code,
    // configuration channel
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [lbp_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  wire logic [lbp_pkg::CFG_DATA_W-1:0]     cfg_data
);

    // ------------------------------------------------------------------------
    // Configuration and stream position registers
    // ------------------------------------------------------------------------
    logic [lbp_pkg::WIDTH_REG_W-1:0] image_width_reg;
    logic [lbp_pkg::HEIGHT_W-1:0]    image_height_reg;
    lbp_pkg::col_t                   in_col_reg,  in_col_next;
    lbp_pkg::row_t                   in_row_reg,  in_row_next;
    lbp_pkg::col_t                   out_col_reg, out_col_next;
    lbp_pkg::row_t                   out_row_reg, out_row_next;
    logic                            done_reg,    done_next;

    // Input stage decode
    logic                            accept;
    logic                            cfg_write;
    logic                            drain;
    lbp_pkg::weff_t                  w_eff;
    lbp_pkg::row_t                   h_eff;
    logic                            input_complete;
    logic                            due;
    logic                            proceed;
    logic                            advance_in;
    logic                            give_result;
    lbp_pkg::weff_t                  in_col_inc;
    lbp_pkg::weff_t                  out_col_inc;
    logic                            in_col_end;
    logic                            out_col_end;
    logic [lbp_pkg::HEIGHT_W:0]      out_row_inc;
    lbp_pkg::col_t                   col;
    lbp_pkg::nbr_mask_t              mask;
    logic                            is_last;

    // Second stage: line buffer data, window update, code
    logic                            s1_push_reg;
    logic                            s1_res_reg;
    lbp_pkg::col_t                   s1_idx_reg;
    lbp_pkg::pix_t                   s1_px_reg;
    lbp_pkg::nbr_mask_t              s1_mask_reg;
    logic                            s1_last_reg;
    logic                            byp_reg;
    lbp_pkg::pix_t                   byp_upper_reg;
    lbp_pkg::pix_t                   byp_lower_reg;
    logic                            byp_next;

    logic [2*lbp_pkg::PIX_W-1:0]     lb_rd_data;
    logic [2*lbp_pkg::PIX_W-1:0]     lb_wr_data;
    lbp_pkg::pix_t                   upper_val;
    lbp_pkg::pix_t                   lower_val;

    lbp_pkg::pix_t                   win_reg  [lbp_pkg::WIN_SIZE];
    lbp_pkg::pix_t                   win_next [lbp_pkg::WIN_SIZE];
    logic [lbp_pkg::WIN_SIZE-1:0]    ge;
    lbp_pkg::result_t                result;

    logic [lbp_pkg::OUT_CNT_W-1:0]   fifo_count;
    logic [lbp_pkg::OUT_CNT_W:0]     fill;
    lbp_pkg::result_t                head;

    // ------------------------------------------------------------------------
    // Handshakes
    // ------------------------------------------------------------------------
    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    // Count the queue plus the result now in flight; hold off during cfg writes
    assign fill        = {1'b0, fifo_count} + (lbp_pkg::OUT_CNT_W + 1)'(s1_res_reg);
    assign pixel_stall = (fill >= (lbp_pkg::OUT_CNT_W + 1)'(lbp_pkg::OUT_DEPTH))
                         || cfg_valid;
    assign accept      = pixel_valid && !pixel_stall;
    assign drain       = (operation == 1'(lbp_pkg::OP_DRAIN));

    // ------------------------------------------------------------------------
    // Effective geometry: a width of zero acts as one, a width beyond the line
    // buffer acts as its full depth, a height of zero acts as one.
    // ------------------------------------------------------------------------
    always_comb
    begin
        if (image_width_reg == '0)
        begin
            w_eff = lbp_pkg::weff_t'(1);
        end
        else if (32'(image_width_reg) > lbp_pkg::MAX_WIDTH)
        begin
            w_eff = lbp_pkg::weff_t'(lbp_pkg::MAX_WIDTH);
        end
        else
        begin
            w_eff = lbp_pkg::weff_t'(image_width_reg);
        end
    end

    assign h_eff = (image_height_reg == '0) ? lbp_pkg::row_t'(1) : image_height_reg;

    // ------------------------------------------------------------------------
    // Input stage: decide what the transaction does from the position state
    // ------------------------------------------------------------------------
    assign input_complete = (in_row_reg >= h_eff);
    // Codes are due once the centre of the first pixel has its right neighbour
    // and the row below
    assign due = (in_row_reg >= lbp_pkg::row_t'(2))
                 || ((in_row_reg == lbp_pkg::row_t'(1)) && (in_col_reg != '0));

    // Drop pixels after the image, drains before it, and all after the last code
    assign proceed     = accept && !done_reg && (drain == input_complete);
    assign advance_in  = proceed && (!drain || !due);
    assign give_result = proceed && due;

    assign in_col_inc  = {1'b0, in_col_reg}  + 1'b1;
    assign out_col_inc = {1'b0, out_col_reg} + 1'b1;
    assign in_col_end  = (in_col_inc  >= w_eff);
    assign out_col_end = (out_col_inc >= w_eff);
    assign out_row_inc = {1'b0, out_row_reg} + 1'b1;

    // A due drain pushes the column right of the next output; wrap at row end
    always_comb
    begin
        if (drain && due)
        begin
            col = out_col_end ? '0 : out_col_inc[lbp_pkg::COL_W-1:0];
        end
        else
        begin
            col = in_col_reg;
        end
    end

    assign mask.top    = (out_row_reg != '0);
    assign mask.bottom = (out_row_inc < {1'b0, h_eff});
    assign mask.left   = (out_col_reg != '0);
    assign mask.right  = !out_col_end;
    assign is_last     = out_col_end && !mask.bottom;

    always_comb
    begin
        in_col_next  = in_col_reg;
        in_row_next  = in_row_reg;
        out_col_next = out_col_reg;
        out_row_next = out_row_reg;
        done_next    = done_reg;
        if (cfg_write)
        begin
            // A register write restarts the stream
            in_col_next  = '0;
            in_row_next  = '0;
            out_col_next = '0;
            out_row_next = '0;
            done_next    = 1'b0;
        end
        else
        begin
            if (advance_in)
            begin
                if (in_col_end)
                begin
                    in_col_next = '0;
                    in_row_next = in_row_reg + 1'b1;
                end
                else
                begin
                    in_col_next = in_col_inc[lbp_pkg::COL_W-1:0];
                end
            end
            if (give_result)
            begin
                if (is_last)
                begin
                    done_next = 1'b1;
                end
                else if (out_col_end)
                begin
                    out_col_next = '0;
                    out_row_next = out_row_inc[lbp_pkg::HEIGHT_W-1:0];
                end
                else
                begin
                    out_col_next = out_col_inc[lbp_pkg::COL_W-1:0];
                end
            end
        end
    end

    // Forward the write of the previous item when it hits the same column
    assign byp_next = proceed && s1_push_reg && (s1_idx_reg == col);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg  <= lbp_pkg::WIDTH_REG_W'(lbp_pkg::WIDTH_RESET);
            image_height_reg <= lbp_pkg::HEIGHT_W'(lbp_pkg::HEIGHT_RESET);
            in_col_reg       <= '0;
            in_row_reg       <= '0;
            out_col_reg      <= '0;
            out_row_reg      <= '0;
            done_reg         <= 1'b0;
            s1_push_reg      <= 1'b0;
            s1_res_reg       <= 1'b0;
            byp_reg          <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    lbp_pkg::REG_IMAGE_WIDTH:
                    begin
                        image_width_reg <= cfg_data[lbp_pkg::WIDTH_REG_W-1:0];
                    end
                    lbp_pkg::REG_IMAGE_HEIGHT:
                    begin
                        image_height_reg <= cfg_data[lbp_pkg::HEIGHT_W-1:0];
                    end
                    default:
                    begin
                        image_width_reg <= image_width_reg;
                    end
                endcase
            end
            in_col_reg  <= in_col_next;
            in_row_reg  <= in_row_next;
            out_col_reg <= out_col_next;
            out_row_reg <= out_row_next;
            done_reg    <= done_next;
            s1_push_reg <= proceed;
            s1_res_reg  <= give_result;
            byp_reg     <= byp_next;
        end
    end

    // Payload of the second stage
    always_ff @(posedge clk)
    begin
        if (proceed)
        begin
            s1_idx_reg    <= col;
            s1_px_reg     <= drain ? '0 : pixel_value;
            s1_mask_reg   <= mask;
            s1_last_reg   <= is_last;
            byp_upper_reg <= lower_val;
            byp_lower_reg <= s1_px_reg;
        end
    end

    // ------------------------------------------------------------------------
    // Line buffers: one RAM word per column, {two rows back, one row back}
    // ------------------------------------------------------------------------
    assign lb_wr_data = {lower_val, s1_px_reg};

    lbp_ram #(
        .WIDTH (2 * lbp_pkg::PIX_W),
        .DEPTH (lbp_pkg::MAX_WIDTH)
    ) u_line_buf (
        .clk     (clk),
        .wr_en   (s1_push_reg),
        .wr_addr (s1_idx_reg),
        .wr_data (lb_wr_data),
        .rd_en   (proceed),
        .rd_addr (col),
        .rd_data (lb_rd_data)
    );

    assign upper_val = byp_reg ? byp_upper_reg : lb_rd_data[2*lbp_pkg::PIX_W-1:lbp_pkg::PIX_W];
    assign lower_val = byp_reg ? byp_lower_reg : lb_rd_data[lbp_pkg::PIX_W-1:0];

    // ------------------------------------------------------------------------
    // Window: advance one column and take the new column on the right
    // ------------------------------------------------------------------------
    always_comb
    begin
        for (int r = 0; r < lbp_pkg::WIN_DIM; r++)
        begin
            for (int c = 0; c < lbp_pkg::WIN_DIM - 1; c++)
            begin
                win_next[r*lbp_pkg::WIN_DIM + c] = win_reg[r*lbp_pkg::WIN_DIM + c + 1];
            end
        end
        win_next[lbp_pkg::WIN_DIM - 1]       = upper_val;
        win_next[2*lbp_pkg::WIN_DIM - 1]     = lower_val;
        win_next[lbp_pkg::WIN_SIZE - 1]      = s1_px_reg;
    end

    always_ff @(posedge clk)
    begin
        if (s1_push_reg)
        begin
            for (int i = 0; i < lbp_pkg::WIN_SIZE; i++)
            begin
                win_reg[i] <= win_next[i];
            end
        end
    end

    // Compare the centre against each neighbour; mask those outside the image
    always_comb
    begin
        for (int i = 0; i < lbp_pkg::WIN_SIZE; i++)
        begin
            ge[i] = (win_next[lbp_pkg::WIN_CTR] <= win_next[i]);
        end
    end

    assign result.code[0] = s1_mask_reg.top    && s1_mask_reg.left  && ge[0];
    assign result.code[1] = s1_mask_reg.top    && ge[1];
    assign result.code[2] = s1_mask_reg.top    && s1_mask_reg.right && ge[2];
    assign result.code[3] = s1_mask_reg.left   && ge[3];
    assign result.code[4] = s1_mask_reg.right  && ge[5];
    assign result.code[5] = s1_mask_reg.bottom && s1_mask_reg.left  && ge[6];
    assign result.code[6] = s1_mask_reg.bottom && ge[7];
    assign result.code[7] = s1_mask_reg.bottom && s1_mask_reg.right && ge[8];
    assign result.last    = s1_last_reg;

    // ------------------------------------------------------------------------
    // Result queue
    // ------------------------------------------------------------------------
    lbp_out_fifo u_out_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (s1_res_reg),
        .push_data (result),
        .pop_valid (code_valid),
        .pop_stall (code_stall),
        .pop_data  (head),
        .count     (fifo_count)
    );

    assign lbp_code  = head.code;
    assign last_code = head.last;

`ifndef SYNTHESIS
    // The queue never holds more than its depth
    a_fifo_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fifo_count <= lbp_pkg::OUT_CNT_W'(lbp_pkg::OUT_DEPTH))
        else $error("result queue overflow");

    // Nothing is pushed for a transaction taken after the last code
    a_quiet_after_done: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && done_reg) |=> !s1_push_reg)
        else $error("transaction processed after the last code");

    // The last code in flight implies the stream is marked finished
    a_last_sets_done: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_res_reg && s1_last_reg) |-> done_reg)
        else $error("last code without finished stream");

    // Forwarding only follows a push into the second stage
    a_byp_source: assert property (@(posedge clk) disable iff (!rst_n)
        byp_reg |-> s1_push_reg && $past(s1_push_reg))
        else $error("line buffer forward without a preceding write");
`endif

endmodule : lbp_filter_3x3
`default_nettype wire

/* hdl/lbp_ram.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lbp_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module lbp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule : lbp_ram
`default_nettype wire

/* hdl/lbp_out_fifo.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lbp_out_fifo
// Small result queue that decouples the filter core from the output stall.
// ----------------------------------------------------------------------------
module lbp_out_fifo (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           push,
    input  wire lbp_pkg::result_t               push_data,
    output logic                                pop_valid,
    input  wire logic                           pop_stall,
    output lbp_pkg::result_t                    pop_data,
    output logic [lbp_pkg::OUT_CNT_W-1:0]       count
);

    lbp_pkg::result_t                 mem_reg [lbp_pkg::OUT_DEPTH];
    logic [lbp_pkg::OUT_PTR_W-1:0]    head_reg, head_next;
    logic [lbp_pkg::OUT_PTR_W-1:0]    tail_reg, tail_next;
    logic [lbp_pkg::OUT_CNT_W-1:0]    count_reg, count_next;
    logic                             pop;

    assign pop_valid = (count_reg != '0);
    assign pop       = pop_valid && !pop_stall;
    assign pop_data  = mem_reg[head_reg];
    assign count     = count_reg;

    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        if (pop)
        begin
            head_next = (head_reg == lbp_pkg::OUT_PTR_W'(lbp_pkg::OUT_DEPTH - 1))
                        ? '0 : head_reg + 1'b1;
        end
        if (push)
        begin
            tail_next = (tail_reg == lbp_pkg::OUT_PTR_W'(lbp_pkg::OUT_DEPTH - 1))
                        ? '0 : tail_reg + 1'b1;
        end
        case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    // Write the entry at the tail
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[tail_reg] <= push_data;
        end
    end

endmodule : lbp_out_fifo
`default_nettype wire
